@@ design/ceu_pkg.sv @@
// Package with operation codes, status flag positions and constants of the execute unit.
package ceu_pkg;

  typedef enum logic [5:0] {
    OP_SEC = 6'd0,
    OP_CLC = 6'd1,
    OP_LDA = 6'd2,
    OP_LDX = 6'd3,
    OP_LDY = 6'd4,
    OP_ADC = 6'd5,
    OP_SBC = 6'd6,
    OP_AND = 6'd7,
    OP_JMP = 6'd8,
    OP_TXS = 6'd9,
    OP_PHA = 6'd10,
    OP_PLA = 6'd11,
    OP_PHP = 6'd12,
    OP_CLI = 6'd13,
    OP_PLP = 6'd14,
    OP_TSX = 6'd15,
    OP_SEI = 6'd16,
    OP_SED = 6'd17,
    OP_CLD = 6'd18,
    OP_STA = 6'd19,
    OP_STX = 6'd20,
    OP_STY = 6'd21,
    OP_DEX = 6'd22,
    OP_DEY = 6'd23,
    OP_INX = 6'd24,
    OP_INY = 6'd25,
    OP_DEC = 6'd26,
    OP_INC = 6'd27,
    OP_BIT = 6'd28,
    OP_BPL = 6'd29,
    OP_BNE = 6'd30,
    OP_CMP = 6'd31,
    OP_CPX = 6'd32,
    OP_CPY = 6'd33
  } kind_e;

  localparam int unsigned FlagN = 7;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] StackPage   = 8'h01;
  localparam logic [7:0] PushBits    = 8'b0011_0000;
  localparam logic [7:0] SpReset     = 8'hFD;
  localparam logic [7:0] StatusReset = 8'h24;

endpackage

@@ design/cpu_instruction_execute_unit_top.sv @@
// Execute unit top level: register file, single-pass operation logic and result register.
//
// The input channel carries one decoded operation per transaction: kind, the
// operand byte and the effective address. The output channel returns one
// result transaction per operation: an optional memory write, an optional
// program counter load and the A, X, Y, SP and status registers after it.
// The operation is evaluated against the architectural registers in the cycle
// it is accepted; those registers and the result register update at that
// edge, so the result appears in the cycle after acceptance.
// One operation is accepted per cycle, limited only by the single result
// register, which frees whenever its transaction is taken.
// When the receiver stalls while a result is held, the input is stalled in
// the same cycle and the held result stays unchanged.
// Reset clears A, X and Y, sets SP to 0xFD and status to 0x24, and empties
// the result register.
module cpu_instruction_execute_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  kind_i,
  input  logic [7:0]  operand_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic        pc_load_o,
  output logic [15:0] pc_value_o,
  output logic [7:0]  acc_out_o,
  output logic [7:0]  x_out_o,
  output logic [7:0]  y_out_o,
  output logic [7:0]  sp_out_o,
  output logic [7:0]  status_out_o
);

  logic [7:0]  acc_q, acc_d;
  logic [7:0]  x_q, x_d;
  logic [7:0]  y_q, y_d;
  logic [7:0]  sp_q, sp_d;
  logic [7:0]  st_q, st_d;
  logic        out_valid_q;
  logic        we_q, we_d;
  logic [15:0] waddr_q, waddr_d;
  logic [7:0]  wdata_q, wdata_d;
  logic        pl_q, pl_d;
  logic [15:0] pcv_q, pcv_d;

  logic        accept;
  logic [7:0]  adc_m;
  logic [8:0]  sum;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff;
  logic [7:0]  sp_inc;
  logic [7:0]  sp_dec;
  logic [7:0]  mem_res;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign adc_m  = (kind_i == ceu_pkg::OP_SBC) ? ~operand_i : operand_i;
  assign sum    = {1'b0, acc_q} + {1'b0, adc_m} + {8'd0, st_q[ceu_pkg::FlagC]};
  assign cmp_reg = (kind_i == ceu_pkg::OP_CPX) ? x_q :
                   (kind_i == ceu_pkg::OP_CPY) ? y_q : acc_q;
  assign diff   = {1'b0, cmp_reg} - {1'b0, operand_i};
  assign sp_inc = sp_q + 8'd1;
  assign sp_dec = sp_q - 8'd1;
  assign mem_res = (kind_i == ceu_pkg::OP_DEC) ? operand_i - 8'd1 : operand_i + 8'd1;

  always_comb begin
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    sp_d    = sp_q;
    st_d    = st_q;
    we_d    = 1'b0;
    waddr_d = 16'd0;
    wdata_d = 8'd0;
    pl_d    = 1'b0;
    pcv_d   = 16'd0;
    case (kind_i)
      ceu_pkg::OP_SEC: st_d[ceu_pkg::FlagC] = 1'b1;
      ceu_pkg::OP_CLC: st_d[ceu_pkg::FlagC] = 1'b0;
      ceu_pkg::OP_LDA, ceu_pkg::OP_PLA: begin
        acc_d = operand_i;
        st_d[ceu_pkg::FlagN] = operand_i[7];
        st_d[ceu_pkg::FlagZ] = (operand_i == 8'd0);
        if (kind_i == ceu_pkg::OP_PLA) begin
          sp_d = sp_inc;
        end
      end
      ceu_pkg::OP_LDX: begin
        x_d = operand_i;
        st_d[ceu_pkg::FlagN] = operand_i[7];
        st_d[ceu_pkg::FlagZ] = (operand_i == 8'd0);
      end
      ceu_pkg::OP_LDY: begin
        y_d = operand_i;
        st_d[ceu_pkg::FlagN] = operand_i[7];
        st_d[ceu_pkg::FlagZ] = (operand_i == 8'd0);
      end
      ceu_pkg::OP_ADC, ceu_pkg::OP_SBC: begin
        acc_d = sum[7:0];
        st_d[ceu_pkg::FlagC] = sum[8];
        st_d[ceu_pkg::FlagV] = ~(acc_q[7] ^ adc_m[7]) & (acc_q[7] ^ sum[7]);
        st_d[ceu_pkg::FlagN] = sum[7];
        st_d[ceu_pkg::FlagZ] = (sum[7:0] == 8'd0);
      end
      ceu_pkg::OP_AND: begin
        acc_d = acc_q & operand_i;
        st_d[ceu_pkg::FlagN] = acc_q[7] & operand_i[7];
        st_d[ceu_pkg::FlagZ] = ((acc_q & operand_i) == 8'd0);
      end
      ceu_pkg::OP_JMP: begin
        pl_d  = 1'b1;
        pcv_d = address_i;
      end
      ceu_pkg::OP_TXS: sp_d = x_q;
      ceu_pkg::OP_PHA, ceu_pkg::OP_PHP: begin
        we_d    = 1'b1;
        waddr_d = {ceu_pkg::StackPage, sp_q};
        wdata_d = (kind_i == ceu_pkg::OP_PHA) ? acc_q : (st_q | ceu_pkg::PushBits);
        sp_d    = sp_dec;
      end
      ceu_pkg::OP_CLI: st_d[ceu_pkg::FlagI] = 1'b0;
      ceu_pkg::OP_PLP: begin
        sp_d = sp_inc;
        st_d = operand_i;
        st_d[ceu_pkg::FlagU] = 1'b1;
        st_d[ceu_pkg::FlagB] = 1'b0;
      end
      ceu_pkg::OP_TSX: begin
        x_d = sp_q;
        st_d[ceu_pkg::FlagN] = sp_q[7];
        st_d[ceu_pkg::FlagZ] = (sp_q == 8'd0);
      end
      ceu_pkg::OP_SEI: st_d[ceu_pkg::FlagI] = 1'b1;
      ceu_pkg::OP_SED: st_d[ceu_pkg::FlagD] = 1'b1;
      ceu_pkg::OP_CLD: st_d[ceu_pkg::FlagD] = 1'b0;
      ceu_pkg::OP_STA: begin
        we_d    = 1'b1;
        waddr_d = address_i;
        wdata_d = acc_q;
      end
      ceu_pkg::OP_STX: begin
        we_d    = 1'b1;
        waddr_d = address_i;
        wdata_d = x_q;
      end
      ceu_pkg::OP_STY: begin
        we_d    = 1'b1;
        waddr_d = address_i;
        wdata_d = y_q;
      end
      ceu_pkg::OP_DEX, ceu_pkg::OP_INX: begin
        x_d = (kind_i == ceu_pkg::OP_DEX) ? x_q - 8'd1 : x_q + 8'd1;
        st_d[ceu_pkg::FlagN] = x_d[7];
        st_d[ceu_pkg::FlagZ] = (x_d == 8'd0);
      end
      ceu_pkg::OP_DEY, ceu_pkg::OP_INY: begin
        y_d = (kind_i == ceu_pkg::OP_DEY) ? y_q - 8'd1 : y_q + 8'd1;
        st_d[ceu_pkg::FlagN] = y_d[7];
        st_d[ceu_pkg::FlagZ] = (y_d == 8'd0);
      end
      ceu_pkg::OP_DEC, ceu_pkg::OP_INC: begin
        we_d    = 1'b1;
        waddr_d = address_i;
        wdata_d = mem_res;
        st_d[ceu_pkg::FlagN] = mem_res[7];
        st_d[ceu_pkg::FlagZ] = (mem_res == 8'd0);
      end
      ceu_pkg::OP_BIT: begin
        st_d[ceu_pkg::FlagN] = operand_i[7];
        st_d[ceu_pkg::FlagV] = operand_i[6];
        st_d[ceu_pkg::FlagZ] = ((acc_q & operand_i) == 8'd0);
      end
      ceu_pkg::OP_BPL: begin
        if (!st_q[ceu_pkg::FlagN]) begin
          pl_d  = 1'b1;
          pcv_d = address_i;
        end
      end
      ceu_pkg::OP_BNE: begin
        if (!st_q[ceu_pkg::FlagZ]) begin
          pl_d  = 1'b1;
          pcv_d = address_i;
        end
      end
      ceu_pkg::OP_CMP, ceu_pkg::OP_CPX, ceu_pkg::OP_CPY: begin
        st_d[ceu_pkg::FlagC] = ~diff[8];
        st_d[ceu_pkg::FlagZ] = (diff[7:0] == 8'd0);
        st_d[ceu_pkg::FlagN] = diff[7];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 8'd0;
      x_q         <= 8'd0;
      y_q         <= 8'd0;
      sp_q        <= ceu_pkg::SpReset;
      st_q        <= ceu_pkg::StatusReset;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_q       <= acc_d;
        x_q         <= x_d;
        y_q         <= y_d;
        sp_q        <= sp_d;
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      we_q    <= we_d;
      waddr_q <= waddr_d;
      wdata_q <= wdata_d;
      pl_q    <= pl_d;
      pcv_q   <= pcv_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = we_q;
  assign write_address_o = waddr_q;
  assign write_data_o    = wdata_q;
  assign pc_load_o       = pl_q;
  assign pc_value_o      = pcv_q;
  assign acc_out_o       = acc_q;
  assign x_out_o         = x_q;
  assign y_out_o         = y_q;
  assign sp_out_o        = sp_q;
  assign status_out_o    = st_q;

endmodule

@@ test/cpu_instruction_execute_unit_top_tb.sv @@
// Self-checking testbench for the execute unit: directed table, random operations, model check.
module cpu_instruction_execute_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomOps     = 362;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int MaxReported   = 10;
  localparam int CalmStretch   = 40;

  localparam logic [5:0] KindUnusedLo = 6'd34;
  localparam logic [5:0] KindUnusedHi = 6'd63;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        pc_load;
    logic [15:0] pc_value;
    logic [7:0]  acc;
    logic [7:0]  idx_x;
    logic [7:0]  idx_y;
    logic [7:0]  sp;
    logic [7:0]  status;
  } exec_result_t;

  typedef struct packed {
    logic [5:0]   kind;
    logic [7:0]   operand;
    logic [15:0]  address;
    logic         typed;
    exec_result_t result;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [5:0]  kind_i = '0;
  logic [7:0]  operand_i = '0;
  logic [15:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        write_enable_o;
  logic [15:0] write_address_o;
  logic [7:0]  write_data_o;
  logic        pc_load_o;
  logic [15:0] pc_value_o;
  logic [7:0]  acc_out_o;
  logic [7:0]  x_out_o;
  logic [7:0]  y_out_o;
  logic [7:0]  sp_out_o;
  logic [7:0]  status_out_o;

  logic [7:0] model_a  = 8'h00;
  logic [7:0] model_x  = 8'h00;
  logic [7:0] model_y  = 8'h00;
  logic [7:0] model_sp = ceu_pkg::SpReset;
  logic [7:0] model_p  = ceu_pkg::StatusReset;

  exec_result_t pending_results[$];
  int mismatch_count = 0;
  bit source_calm = 1'b0;
  bit sink_calm = 1'b0;

  op_row_t directed_ops [38] = '{
    '{ceu_pkg::OP_JMP, 8'h00, 16'hFFFF, 1'b1,
      '{1'b0, 16'h0000, 8'h00, 1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24}},
    '{ceu_pkg::OP_PHP, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 16'h01FD, 8'h34, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFC, 8'h24}},
    '{ceu_pkg::OP_SEC, 8'h00, 16'h0000, 1'b1,
      '{1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFC, 8'h25}},
    '{ceu_pkg::OP_LDA, 8'hFF, 16'h0000, 1'b1,
      '{1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'hFC, 8'hA5}},
    '{KindUnusedHi, 8'h00, 16'h0000, 1'b1,
      '{1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'hFC, 8'hA5}},
    '{ceu_pkg::OP_ADC, 8'h01, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_LDA, 8'h7F, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_ADC, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_SBC, 8'hFF, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_AND, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_CLC, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_LDX, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_TXS, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_PHA, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_PLA, 8'h80, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_PLP, 8'hFF, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_TSX, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_CLI, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_SEI, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_SED, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_CLD, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_LDY, 8'h80, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_STA, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_STX, 8'h00, 16'hFFFF, 1'b0, '0},
    '{ceu_pkg::OP_STY, 8'h00, 16'h8000, 1'b0, '0},
    '{ceu_pkg::OP_DEX, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_DEY, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_INX, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_INY, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_DEC, 8'h00, 16'h1234, 1'b0, '0},
    '{ceu_pkg::OP_INC, 8'hFF, 16'hFFFF, 1'b0, '0},
    '{ceu_pkg::OP_BIT, 8'hC0, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_BPL, 8'h00, 16'hABCD, 1'b0, '0},
    '{ceu_pkg::OP_BNE, 8'h00, 16'h5555, 1'b0, '0},
    '{ceu_pkg::OP_CMP, 8'h80, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_CPX, 8'h00, 16'h0000, 1'b0, '0},
    '{ceu_pkg::OP_CPY, 8'hFF, 16'h0000, 1'b0, '0},
    '{KindUnusedLo, 8'hFF, 16'hFFFF, 1'b0, '0}
  };

  cpu_instruction_execute_unit_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .operand_i       (operand_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .pc_load_o       (pc_load_o),
    .pc_value_o      (pc_value_o),
    .acc_out_o       (acc_out_o),
    .x_out_o         (x_out_o),
    .y_out_o         (y_out_o),
    .sp_out_o        (sp_out_o),
    .status_out_o    (status_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic set_nz(input logic [7:0] value);
    model_p[ceu_pkg::FlagN] = value[7];
    model_p[ceu_pkg::FlagZ] = (value == 8'h00);
  endtask

  task automatic execute_op(input logic [5:0] k, input logic [7:0] m,
                            input logic [15:0] a, output exec_result_t r);
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] lhs;
    logic [7:0] diff;
    r = '0;
    case (k)
      ceu_pkg::OP_SEC: model_p[ceu_pkg::FlagC] = 1'b1;
      ceu_pkg::OP_CLC: model_p[ceu_pkg::FlagC] = 1'b0;
      ceu_pkg::OP_LDA: begin
        model_a = m;
        set_nz(model_a);
      end
      ceu_pkg::OP_LDX: begin
        model_x = m;
        set_nz(model_x);
      end
      ceu_pkg::OP_LDY: begin
        model_y = m;
        set_nz(model_y);
      end
      ceu_pkg::OP_ADC, ceu_pkg::OP_SBC: begin
        addend = (k == ceu_pkg::OP_SBC) ? ~m : m;
        sum = {1'b0, model_a} + {1'b0, addend} + {8'h00, model_p[ceu_pkg::FlagC]};
        model_p[ceu_pkg::FlagC] = sum[8];
        model_p[ceu_pkg::FlagV] = ~(model_a[7] ^ addend[7]) & (model_a[7] ^ sum[7]);
        model_a = sum[7:0];
        set_nz(model_a);
      end
      ceu_pkg::OP_AND: begin
        model_a = model_a & m;
        set_nz(model_a);
      end
      ceu_pkg::OP_JMP: begin
        r.pc_load = 1'b1;
        r.pc_value = a;
      end
      ceu_pkg::OP_TXS: model_sp = model_x;
      ceu_pkg::OP_PHA, ceu_pkg::OP_PHP: begin
        r.write_enable = 1'b1;
        r.write_address = {ceu_pkg::StackPage, model_sp};
        r.write_data = (k == ceu_pkg::OP_PHA) ? model_a : (model_p | ceu_pkg::PushBits);
        model_sp = model_sp - 8'd1;
      end
      ceu_pkg::OP_PLA: begin
        model_sp = model_sp + 8'd1;
        model_a = m;
        set_nz(model_a);
      end
      ceu_pkg::OP_CLI: model_p[ceu_pkg::FlagI] = 1'b0;
      ceu_pkg::OP_PLP: begin
        model_sp = model_sp + 8'd1;
        model_p = m & ~ceu_pkg::PushBits;
        model_p[ceu_pkg::FlagU] = 1'b1;
      end
      ceu_pkg::OP_TSX: begin
        model_x = model_sp;
        set_nz(model_x);
      end
      ceu_pkg::OP_SEI: model_p[ceu_pkg::FlagI] = 1'b1;
      ceu_pkg::OP_SED: model_p[ceu_pkg::FlagD] = 1'b1;
      ceu_pkg::OP_CLD: model_p[ceu_pkg::FlagD] = 1'b0;
      ceu_pkg::OP_STA, ceu_pkg::OP_STX, ceu_pkg::OP_STY: begin
        r.write_enable = 1'b1;
        r.write_address = a;
        r.write_data = (k == ceu_pkg::OP_STA) ? model_a :
                       (k == ceu_pkg::OP_STX) ? model_x : model_y;
      end
      ceu_pkg::OP_DEX: begin
        model_x = model_x - 8'd1;
        set_nz(model_x);
      end
      ceu_pkg::OP_DEY: begin
        model_y = model_y - 8'd1;
        set_nz(model_y);
      end
      ceu_pkg::OP_INX: begin
        model_x = model_x + 8'd1;
        set_nz(model_x);
      end
      ceu_pkg::OP_INY: begin
        model_y = model_y + 8'd1;
        set_nz(model_y);
      end
      ceu_pkg::OP_DEC, ceu_pkg::OP_INC: begin
        r.write_enable = 1'b1;
        r.write_address = a;
        r.write_data = (k == ceu_pkg::OP_DEC) ? m - 8'd1 : m + 8'd1;
        set_nz(r.write_data);
      end
      ceu_pkg::OP_BIT: begin
        model_p[ceu_pkg::FlagN] = m[7];
        model_p[ceu_pkg::FlagV] = m[6];
        model_p[ceu_pkg::FlagZ] = ((m & model_a) == 8'h00);
      end
      ceu_pkg::OP_BPL, ceu_pkg::OP_BNE: begin
        if (((k == ceu_pkg::OP_BPL) && !model_p[ceu_pkg::FlagN]) ||
            ((k == ceu_pkg::OP_BNE) && !model_p[ceu_pkg::FlagZ])) begin
          r.pc_load = 1'b1;
          r.pc_value = a;
        end
      end
      ceu_pkg::OP_CMP, ceu_pkg::OP_CPX, ceu_pkg::OP_CPY: begin
        lhs = (k == ceu_pkg::OP_CMP) ? model_a :
              (k == ceu_pkg::OP_CPX) ? model_x : model_y;
        diff = lhs - m;
        model_p[ceu_pkg::FlagC] = (lhs >= m);
        model_p[ceu_pkg::FlagZ] = (lhs == m);
        model_p[ceu_pkg::FlagN] = diff[7];
      end
      default: begin
      end
    endcase
    r.acc = model_a;
    r.idx_x = model_x;
    r.idx_y = model_y;
    r.sp = model_sp;
    r.status = model_p;
  endtask

  task automatic issue_op(input op_row_t row);
    int gap;
    exec_result_t predicted;
    gap = source_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= row.kind;
    operand_i <= row.operand;
    address_i <= row.address;
    do @(posedge clk_i); while (in_stall_o);
    execute_op(row.kind, row.operand, row.address, predicted);
    pending_results.push_back(row.typed ? row.result : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input int index,
                             input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MaxReported) begin
        $display("result %0d: %s expected %h, got %h", index, name, want, got);
      end
    end
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 4)];
    end
    return 8'($urandom());
  endfunction

  initial begin : result_sink
    int stall_cycles;
    int taken;
    exec_result_t want;
    taken = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall_cycles = sink_calm ? 0 : $urandom_range(0, 13);
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("result %0d: transaction arrived with nothing expected", taken);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("write_enable", taken, 16'(write_enable_o), 16'(want.write_enable));
        check_field("write_address", taken, write_address_o, want.write_address);
        check_field("write_data", taken, 16'(write_data_o), 16'(want.write_data));
        check_field("pc_load", taken, 16'(pc_load_o), 16'(want.pc_load));
        check_field("pc_value", taken, pc_value_o, want.pc_value);
        check_field("acc_out", taken, 16'(acc_out_o), 16'(want.acc));
        check_field("x_out", taken, 16'(x_out_o), 16'(want.idx_x));
        check_field("y_out", taken, 16'(y_out_o), 16'(want.idx_y));
        check_field("sp_out", taken, 16'(sp_out_o), 16'(want.sp));
        check_field("status_out", taken, 16'(status_out_o), 16'(want.status));
      end
      taken++;
      if (taken % CalmStretch == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("cpu_instruction_execute_unit_top_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int ops_sent;
    bit paused;
    op_row_t row;
    ops_sent = 0;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i]) begin
      issue_op(directed_ops[i]);
    end
    drain_results();

    while (ops_sent < RandomOps) begin
      if (!paused && ops_sent == RandomOps / 2) begin
        paused = 1'b1;
        drain_results();
      end
      row = '0;
      if ($urandom_range(0, 19) == 0) begin
        row.kind = 6'($urandom_range(KindUnusedLo, KindUnusedHi));
      end else begin
        row.kind = 6'($urandom_range(ceu_pkg::OP_SEC, ceu_pkg::OP_CPY));
      end
      row.operand = pick_operand();
      case ($urandom_range(0, 7))
        0: row.address = 16'h0000;
        1: row.address = 16'hFFFF;
        default: row.address = 16'($urandom());
      endcase
      issue_op(row);
      ops_sent++;
      if (ops_sent % CalmStretch == 0) begin
        source_calm = ($urandom_range(0, 3) == 0);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("cpu_instruction_execute_unit_top_tb OK");
    end else begin
      $display("cpu_instruction_execute_unit_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ceu_pkg.sv
design/cpu_instruction_execute_unit_top.sv
test/cpu_instruction_execute_unit_top_tb.sv
